// File: rtl/mlfq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mlfq_pkg: shared types and constants of the feedback queue scheduler
// Sizes of the task table and level queues, field widths and the handshake
// structures exchanged between the top level and the queue pointer block.
// ----------------------------------------------------------------------------
package mlfq_pkg;

	localparam int MAX_TASKS = 16;
	localparam int LEVELS    = 4;

	localparam int IDX_W   = $clog2(MAX_TASKS);
	localparam int CNT_W   = $clog2(MAX_TASKS + 1);
	localparam int LVL_W   = $clog2(LEVELS);
	localparam int QADDR_W = LVL_W + IDX_W;
	localparam int QDEPTH  = 2 ** QADDR_W;

	localparam int TASK_W   = 4;
	localparam int BURST_W  = 12;
	localparam int START_W  = 2;
	localparam int TIME_W   = 16;
	localparam int QUANT_W  = 8;
	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 40;

	localparam logic [QUANT_W-1:0] QUANT_RESET = 8'd2;

	typedef logic [LVL_W-1:0]   lvl_t;
	typedef logic [IDX_W-1:0]   idx_t;
	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [TASK_W-1:0]  task_t;
	typedef logic [BURST_W-1:0] burst_t;
	typedef logic [TIME_W-1:0]  time_t;

	typedef enum logic {
		CMD_ARRIVE   = 1'b0,
		CMD_DISPATCH = 1'b1
	} cmd_t;

	typedef struct packed {
		logic push;
		lvl_t push_lvl;
		logic pop;
		lvl_t pop_lvl;
	} qptr_req_t;

	typedef struct packed {
		logic push_ok;
		idx_t push_slot;
		logic any;
		lvl_t top_lvl;
		idx_t top_head;
	} qptr_stat_t;

	function automatic lvl_t clamp_level(input logic [START_W-1:0] s);
		if (int'(s) > LEVELS - 1) begin
			return lvl_t'(LEVELS - 1);
		end
		return lvl_t'(s);
	endfunction

endpackage
`default_nettype wire

// File: rtl/mlfq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mlfq_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one registered read per cycle; the read data holds while the
// read enable is low.
// ----------------------------------------------------------------------------
module mlfq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// File: rtl/mlfq_qptr.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mlfq_qptr: head and fill count of every level queue
// Gives the tail slot of the level being pushed, the highest non-empty level
// and its head, and applies one push and one pop per cycle.
// ----------------------------------------------------------------------------
module mlfq_qptr (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mlfq_pkg::qptr_req_t    req,
	output mlfq_pkg::qptr_stat_t   stat
);

	mlfq_pkg::idx_t head_q [mlfq_pkg::LEVELS];
	mlfq_pkg::cnt_t cnt_q  [mlfq_pkg::LEVELS];

	logic [mlfq_pkg::IDX_W:0] slot_sum;

	always_comb begin
		stat.push_ok = int'(cnt_q[req.push_lvl]) < mlfq_pkg::MAX_TASKS;
		slot_sum = {1'b0, head_q[req.push_lvl]}
			+ (mlfq_pkg::IDX_W + 1)'(cnt_q[req.push_lvl]);
		if (int'(slot_sum) >= mlfq_pkg::MAX_TASKS) begin
			slot_sum = slot_sum - (mlfq_pkg::IDX_W + 1)'(mlfq_pkg::MAX_TASKS);
		end
		stat.push_slot = mlfq_pkg::idx_t'(slot_sum);

		stat.any = 1'b0;
		stat.top_lvl = '0;
		for (int l = mlfq_pkg::LEVELS - 1; l >= 0; l--) begin
			if (cnt_q[l] != '0) begin
				stat.any = 1'b1;
				stat.top_lvl = mlfq_pkg::lvl_t'(l);
			end
		end
		stat.top_head = head_q[stat.top_lvl];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < mlfq_pkg::LEVELS; l++) begin
				head_q[l] <= '0;
				cnt_q[l]  <= '0;
			end
		end else begin
			for (int l = 0; l < mlfq_pkg::LEVELS; l++) begin
				if (req.pop && req.pop_lvl == mlfq_pkg::lvl_t'(l)) begin
					if (head_q[l] == mlfq_pkg::idx_t'(mlfq_pkg::MAX_TASKS - 1)) begin
						head_q[l] <= '0;
					end else begin
						head_q[l] <= head_q[l] + mlfq_pkg::idx_t'(1);
					end
				end
				cnt_q[l] <= cnt_q[l]
					+ mlfq_pkg::cnt_t'(req.push && stat.push_ok
						&& req.push_lvl == mlfq_pkg::lvl_t'(l))
					- mlfq_pkg::cnt_t'(req.pop && req.pop_lvl == mlfq_pkg::lvl_t'(l));
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/mlfq_scheduler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mlfq_scheduler: four-level feedback queue scheduler
// Arrivals join their starting level; each dispatch serves the head of the
// highest non-empty level, round robin with a quantum above the last level.
// ----------------------------------------------------------------------------
//  Channel  Dir  Transfer               Content
//  s_*      in   s_tvalid & s_tready    tuser cmd, tdata task arrival fields
//  m_*      out  m_tvalid & m_tready    tuser idle, tdata slice report
//  cfg_*    in   cfg_wen                quantum
//
// An arrival is written to the queue and burst memories as it is accepted. A
// dispatch runs through these steps: accept and re-queue of the preempted
// task, level select with queue memory read, remaining-burst memory read,
// then write-back and result. A dispatch that finds nothing ready ends after
// the level select step and reports idle from it. Input is taken only between
// items; a waiting result stalls the next dispatch in its last step, arrivals
// go on.
// Reset clears pointers, counts, clock and pending task; no clearing pass.
// ----------------------------------------------------------------------------
module mlfq_scheduler (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic [mlfq_pkg::QUANT_W-1:0]  cfg_wdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// task_id[3:0], burst[15:4], start_level[17:16], arrival_time[33:18]
	input  logic [mlfq_pkg::S_DATA_W-1:0] s_tdata,
	// cmd[0]
	input  logic [0:0]                    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// run_task[3:0], run_length[15:4], finish_time[31:16], completed[32],
	// served_level[34:33]
	output logic [mlfq_pkg::M_DATA_W-1:0] m_tdata,
	// idle[0]
	output logic [0:0]                    m_tuser
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SEL  = 4'b0010,
		ST_RD1  = 4'b0100,
		ST_RD2  = 4'b1000
	} state_t;

	state_t state_q;

	logic [mlfq_pkg::QUANT_W-1:0] quantum_q;
	mlfq_pkg::time_t time_q;
	logic            pend_valid_q;
	mlfq_pkg::task_t pend_task_q;
	mlfq_pkg::lvl_t  pend_lvl_q;
	mlfq_pkg::lvl_t  lvl_s1;
	mlfq_pkg::task_t task_s2;

	logic             out_valid_q;
	mlfq_pkg::task_t  out_task_q;
	mlfq_pkg::burst_t out_run_q;
	mlfq_pkg::time_t  out_time_q;
	logic             out_done_q;
	mlfq_pkg::lvl_t   out_lvl_q;
	logic             out_idle_q;

	mlfq_pkg::cmd_t   in_cmd;
	mlfq_pkg::task_t  in_task;
	mlfq_pkg::burst_t in_burst;
	logic [mlfq_pkg::START_W-1:0] in_start;
	mlfq_pkg::time_t  in_at;

	logic accept, arrive_ok, dispatch_acc, any_ready, out_free;
	logic sel_idle_fire, rd2_fire;

	mlfq_pkg::qptr_req_t  qreq;
	mlfq_pkg::qptr_stat_t qstat;

	logic                           qram_we;
	logic [mlfq_pkg::QADDR_W-1:0]   qram_waddr, qram_raddr;
	mlfq_pkg::task_t                qram_wdata, qram_rdata;
	mlfq_pkg::task_t                push_task;

	logic            bram_we;
	mlfq_pkg::idx_t  bram_waddr;
	mlfq_pkg::burst_t bram_wdata, bram_rdata;

	logic [mlfq_pkg::QUANT_W-1:0] q_eff;
	mlfq_pkg::burst_t q_ext, run_len, new_rem;
	logic demote;

	assign in_cmd   = mlfq_pkg::cmd_t'(s_tuser[0]);
	assign in_task  = s_tdata[3:0];
	assign in_burst = s_tdata[15:4];
	assign in_start = s_tdata[17:16];
	assign in_at    = s_tdata[33:18];

	assign s_tready     = (state_q == ST_IDLE);
	assign accept       = s_tvalid && s_tready;
	assign dispatch_acc = accept && in_cmd == mlfq_pkg::CMD_DISPATCH;
	assign arrive_ok    = accept && in_cmd == mlfq_pkg::CMD_ARRIVE && in_burst != '0
		&& int'(in_task) < mlfq_pkg::MAX_TASKS;
	assign any_ready    = pend_valid_q || qstat.any;
	assign out_free     = !out_valid_q || m_tready;

	assign sel_idle_fire = (state_q == ST_SEL) && !qstat.any && out_free;
	assign rd2_fire      = (state_q == ST_RD2) && out_free;

	always_comb begin
		qreq.push     = arrive_ok || (dispatch_acc && pend_valid_q);
		qreq.push_lvl = (in_cmd == mlfq_pkg::CMD_ARRIVE) ? mlfq_pkg::clamp_level(in_start)
			: pend_lvl_q;
		qreq.pop      = (state_q == ST_SEL) && qstat.any;
		qreq.pop_lvl  = qstat.top_lvl;
	end

	mlfq_qptr u_qptr (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (qreq),
		.stat   (qstat)
	);

	assign push_task  = (in_cmd == mlfq_pkg::CMD_ARRIVE) ? in_task : pend_task_q;
	assign qram_we    = qreq.push && qstat.push_ok;
	assign qram_waddr = {qreq.push_lvl, qstat.push_slot};
	assign qram_wdata = push_task;
	assign qram_raddr = {qstat.top_lvl, qstat.top_head};

	mlfq_ram #(
		.WIDTH (mlfq_pkg::TASK_W),
		.DEPTH (mlfq_pkg::QDEPTH)
	) u_queue_ram (
		.clk   (clk),
		.we    (qram_we),
		.waddr (qram_waddr),
		.wdata (qram_wdata),
		.re    (qreq.pop),
		.raddr (qram_raddr),
		.rdata (qram_rdata)
	);

	always_comb begin
		q_eff   = (quantum_q == '0) ? mlfq_pkg::QUANT_W'(1) : quantum_q;
		q_ext   = mlfq_pkg::burst_t'(q_eff);
		demote  = int'(lvl_s1) < mlfq_pkg::LEVELS - 1 && bram_rdata > q_ext;
		run_len = demote ? q_ext : bram_rdata;
		new_rem = demote ? bram_rdata - q_ext : '0;
	end

	assign bram_we    = arrive_ok || rd2_fire;
	assign bram_waddr = arrive_ok ? mlfq_pkg::idx_t'(in_task) : mlfq_pkg::idx_t'(task_s2);
	assign bram_wdata = arrive_ok ? in_burst : new_rem;

	mlfq_ram #(
		.WIDTH (mlfq_pkg::BURST_W),
		.DEPTH (mlfq_pkg::MAX_TASKS)
	) u_burst_ram (
		.clk   (clk),
		.we    (bram_we),
		.waddr (bram_waddr),
		.wdata (bram_wdata),
		.re    (state_q == ST_RD1),
		.raddr (mlfq_pkg::idx_t'(qram_rdata)),
		.rdata (bram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (dispatch_acc) begin
						state_q <= ST_SEL;
					end
				end
				ST_SEL: begin
					if (qstat.any) begin
						state_q <= ST_RD1;
					end else if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RD1: begin
					state_q <= ST_RD2;
				end
				ST_RD2: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q    <= mlfq_pkg::QUANT_RESET;
			time_q       <= '0;
			pend_valid_q <= 1'b0;
			pend_task_q  <= '0;
			pend_lvl_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wen) begin
				quantum_q <= cfg_wdata;
			end
			if (arrive_ok && !any_ready && in_at > time_q) begin
				time_q <= in_at;
			end else if (rd2_fire) begin
				time_q <= time_q + mlfq_pkg::time_t'(run_len);
			end
			if (dispatch_acc) begin
				pend_valid_q <= 1'b0;
			end else if (rd2_fire && demote) begin
				pend_valid_q <= 1'b1;
				pend_task_q  <= task_s2;
				pend_lvl_q   <= lvl_s1 + mlfq_pkg::lvl_t'(1);
			end
			if (sel_idle_fire || rd2_fire) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (qreq.pop) begin
			lvl_s1 <= qstat.top_lvl;
		end
		if (state_q == ST_RD1) begin
			task_s2 <= qram_rdata;
		end
		if (sel_idle_fire) begin
			out_task_q <= '0;
			out_run_q  <= '0;
			out_time_q <= time_q;
			out_done_q <= 1'b0;
			out_lvl_q  <= '0;
			out_idle_q <= 1'b1;
		end else if (rd2_fire) begin
			out_task_q <= task_s2;
			out_run_q  <= run_len;
			out_time_q <= time_q + mlfq_pkg::time_t'(run_len);
			out_done_q <= !demote;
			out_lvl_q  <= lvl_s1;
			out_idle_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {
		(mlfq_pkg::M_DATA_W - 33 - mlfq_pkg::LVL_W)'(0),
		out_lvl_q, out_done_q, out_time_q, out_run_q, out_task_q
	};
	assign m_tuser  = out_idle_q;

endmodule
`default_nettype wire

// File: rtl/mlfq_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mlfq_checker: port-level checks of the feedback queue scheduler
// Watches the stream ports and is bound to every instance of the top level.
// ----------------------------------------------------------------------------
module mlfq_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [0:0]                    s_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [mlfq_pkg::M_DATA_W-1:0] m_tdata,
	input logic [0:0]                    m_tuser
);

	// A stalled result keeps its contents until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// An idle report carries no task, no run and no completion.
	a_idle_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[15:0] == '0 && m_tdata[34:32] == '0)
		else $error("idle report with task fields set");

	// A preempted slice has a non-zero length (it ran a full quantum) and never comes from the last level.
	a_preempt: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] && !m_tdata[32]
		|-> m_tdata[15:4] != '0 && m_tdata[34:33] != 2'(mlfq_pkg::LEVELS - 1))
		else $error("preempted slice with bad length or level");

	// A dispatch transfer is followed by the scheduler working on it.
	a_dispatch_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser[0] == mlfq_pkg::CMD_DISPATCH |=> !s_tready)
		else $error("input ready straight after a dispatch");

endmodule

bind mlfq_scheduler mlfq_checker u_mlfq_checker (.*);
`default_nettype wire
